FILE: sv/ilms_pkg.sv
// ----------------------------------------------------------------------------
// ilms_pkg
// Shared types and constants of the Ising lattice Metropolis step block.
// ----------------------------------------------------------------------------
package ilms_pkg;

  localparam int unsigned MAX_SIDE_DEF = 64;

  localparam int unsigned SIDE_W   = 7;
  localparam int unsigned THR_W    = 33;
  localparam int unsigned BURN_W   = 32;
  localparam int unsigned CHANCE_W = 32;
  localparam int unsigned ENERGY_W = 15;
  localparam int unsigned MAG_W    = 14;
  localparam int unsigned SWEEP_W  = 32;
  localparam int unsigned SUM_W    = 48;
  localparam int unsigned SQSUM_W  = 64;
  localparam int unsigned ABSSUM_W = 47;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 33;

  localparam logic [SIDE_W-1:0] SIDE_RST = 7'd16;
  localparam logic [BURN_W-1:0] BURN_RST = 32'd5000;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SIDE      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THR_FOUR  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_THR_EIGHT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BURN      = 2'd3;

  // item kinds
  localparam logic KIND_RESTART = 1'b0;
  localparam logic KIND_FLIP    = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_LAST,
    ST_DECIDE,
    ST_SQUARE,
    ST_ACCUM
  } state_e;

endpackage

FILE: sv/ilms_ram.sv
// ----------------------------------------------------------------------------
// ilms_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ilms_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: sv/ising_lattice_metropolis_step_top.sv
// ----------------------------------------------------------------------------
// ising_lattice_metropolis_step_top
// Metropolis single-spin-flip update of a periodic square Ising lattice.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: an item transfers on a rising edge with start high and
//   busy low. kind_i = 0 restarts the lattice and the sums, kind_i = 1 tries
//   to flip the spin at row_i/col_i with random fraction chance_i.
//   Each item gives one result: res_strobe_o is high for exactly one cycle
//   and the result fields are valid in that cycle. The receiver cannot stall.
//   Configuration: cfg_we_i writes cfg_wdata_i into register cfg_idx_i
//   (0 side, 1 threshold for dE 4, 2 threshold for dE 8, 3 burn-in sweeps).
// Timing:
//   A flip attempt makes five reads of the single read port of the spin RAM
//   (site and four neighbors), then waits in a state for the last read data
//   and then decides and writes back in the DECIDE state. A sweep that is
//   summed adds a squaring state, then the saturating adds. busy drops with
//   the strobe, so a new flip transfers only after the last one has strobed.
//   A bad site strobes in the next cycle; busy stays low.
//   A restart strobes in the next cycle, with busy high for a clearing pass
//   over all MAX_SIDE*MAX_SIDE sites (4096 by default) that sets every spin
//   up. Reset runs the same clearing pass before the first item transfers.
// ----------------------------------------------------------------------------
module ising_lattice_metropolis_step_top #(
  parameter int unsigned MAX_SIDE = ilms_pkg::MAX_SIDE_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [ilms_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [ilms_pkg::CFG_DATA_W-1:0]       cfg_wdata_i,
  input  logic                                  start,
  output logic                                  busy,
  input  logic                                  kind_i,
  input  logic [$clog2(MAX_SIDE)-1:0]           row_i,
  input  logic [$clog2(MAX_SIDE)-1:0]           col_i,
  input  logic [ilms_pkg::CHANCE_W-1:0]         chance_i,
  output logic                                  res_strobe_o,
  output logic                                  accepted_o,
  output logic                                  bad_site_o,
  output logic signed [ilms_pkg::ENERGY_W-1:0]  energy_o,
  output logic signed [ilms_pkg::MAG_W-1:0]     magnetization_o,
  output logic                                  sweep_done_o,
  output logic [ilms_pkg::SWEEP_W-1:0]          sweep_count_o,
  output logic signed [ilms_pkg::SUM_W-1:0]     sum_energy_o,
  output logic [ilms_pkg::SQSUM_W-1:0]          sum_energy_sq_o,
  output logic signed [ilms_pkg::SUM_W-1:0]     sum_mag_o,
  output logic [ilms_pkg::SQSUM_W-1:0]          sum_mag_sq_o,
  output logic [ilms_pkg::ABSSUM_W-1:0]         sum_abs_mag_o
);

  localparam int unsigned RowW  = $clog2(MAX_SIDE);
  localparam int unsigned AddrW = 2 * RowW;
  localparam int unsigned Depth = MAX_SIDE * MAX_SIDE;
  localparam int unsigned SW    = $clog2(MAX_SIDE + 1);
  localparam int unsigned EffW  = (SW > ilms_pkg::SIDE_W) ? SW : ilms_pkg::SIDE_W;
  localparam int unsigned SqW   = 2 * EffW;
  localparam int unsigned CntW  = $clog2(Depth + 1);
  localparam int unsigned EW    = ilms_pkg::ENERGY_W;
  localparam int unsigned MW    = ilms_pkg::MAG_W;

  // configuration registers
  logic [ilms_pkg::SIDE_W-1:0] side_q;
  logic [ilms_pkg::THR_W-1:0]  thr_four_q, thr_eight_q;
  logic [ilms_pkg::BURN_W-1:0] burn_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q      <= ilms_pkg::SIDE_RST;
      thr_four_q  <= '0;
      thr_eight_q <= '0;
      burn_q      <= ilms_pkg::BURN_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ilms_pkg::CFG_SIDE:      side_q      <= cfg_wdata_i[ilms_pkg::SIDE_W-1:0];
        ilms_pkg::CFG_THR_FOUR:  thr_four_q  <= cfg_wdata_i;
        ilms_pkg::CFG_THR_EIGHT: thr_eight_q <= cfg_wdata_i;
        ilms_pkg::CFG_BURN:      burn_q      <= cfg_wdata_i[ilms_pkg::BURN_W-1:0];
        default: ;
      endcase
    end
  end

  // effective side, clamped to 2..MAX_SIDE
  logic [EffW-1:0] side_ext, eff_side;
  logic [SqW-1:0]  side_sq;

  always_comb begin
    side_ext = EffW'(side_q);
    if (side_ext < EffW'(2)) begin
      eff_side = EffW'(2);
    end else if (side_ext > EffW'(MAX_SIDE)) begin
      eff_side = EffW'(MAX_SIDE);
    end else begin
      eff_side = side_ext;
    end
    side_sq = SqW'(eff_side) * SqW'(eff_side);
  end

  // state
  ilms_pkg::state_e state_q, state_d;

  logic [AddrW-1:0]              clr_cnt_q;
  logic [2:0]                    rd_cnt_q;
  logic [4:0]                    taps_q;
  logic [RowW-1:0]               row_q, col_q;
  logic [ilms_pkg::CHANCE_W-1:0] chance_q;

  logic signed [EW-1:0]             energy_q;
  logic signed [MW-1:0]             mag_q;
  logic [CntW-1:0]                  attempts_q;
  logic [ilms_pkg::SWEEP_W-1:0]     sweeps_q;
  logic signed [ilms_pkg::SUM_W-1:0] acc_e_q, acc_m_q;
  logic [ilms_pkg::SQSUM_W-1:0]     acc_esq_q, acc_msq_q;
  logic [ilms_pkg::ABSSUM_W-1:0]    acc_abs_q;
  logic [2*EW-1:0]                  esq_q;
  logic [2*MW-1:0]                  msq_q;
  logic [MW-1:0]                    mabs_q;

  logic strobe_q, accepted_q, bad_q, done_q;

  // item checks
  logic bad_in;
  assign bad_in = (EffW'(row_i) >= eff_side) || (EffW'(col_i) >= eff_side);

  // wrapped neighbor coordinates
  logic [RowW-1:0] rp, rm, cp, cm;
  always_comb begin
    rp = (EffW'(row_q) + EffW'(1) == eff_side) ? '0 : row_q + RowW'(1);
    rm = (row_q == '0) ? RowW'(eff_side - EffW'(1)) : row_q - RowW'(1);
    cp = (EffW'(col_q) + EffW'(1) == eff_side) ? '0 : col_q + RowW'(1);
    cm = (col_q == '0) ? RowW'(eff_side - EffW'(1)) : col_q - RowW'(1);
  end

  logic [AddrW-1:0] rd_addr;
  always_comb begin
    unique case (rd_cnt_q)
      3'd1:    rd_addr = {rp, col_q};
      3'd2:    rd_addr = {rm, col_q};
      3'd3:    rd_addr = {row_q, cp};
      3'd4:    rd_addr = {row_q, cm};
      default: rd_addr = {row_q, col_q};
    endcase
  end

  // decision: taps_q[4] is the site, [3:0] the neighbors
  logic [3:0]              same_vec;
  logic [2:0]              same_cnt;
  logic                    flip;
  logic signed [5:0]       delta_e;
  logic signed [EW-1:0]    energy_new;
  logic signed [MW-1:0]    mag_new;
  logic [CntW-1:0]         attempts_inc;
  logic                    wrap;
  logic                    do_sum;

  always_comb begin
    same_vec = ~(taps_q[3:0] ^ {4{taps_q[4]}});
    same_cnt = 3'($countones(same_vec));
    priority if (same_cnt <= 3'd2) begin
      flip = 1'b1;
    end else if (same_cnt == 3'd3) begin
      flip = {1'b0, chance_q} <= thr_four_q;
    end else begin
      flip = {1'b0, chance_q} <= thr_eight_q;
    end
    delta_e    = $signed({1'b0, same_cnt, 2'b00}) - 6'sd8;
    energy_new = energy_q + EW'(delta_e);
    mag_new    = taps_q[4] ? mag_q - MW'(2) : mag_q + MW'(2);
    attempts_inc = attempts_q + CntW'(1);
    wrap   = SqW'(attempts_inc) >= side_sq;
    do_sum = sweeps_q > burn_q;
  end

  // RAM
  logic             ram_we, ram_wdata;
  logic [AddrW-1:0] ram_waddr;
  logic             ram_rdata;

  ilms_ram #(
    .WIDTH(1),
    .DEPTH(Depth)
  ) u_spin_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(rd_addr),
    .rdata_o(ram_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ilms_pkg::ST_CLEAR:  if (&clr_cnt_q) state_d = ilms_pkg::ST_IDLE;
      ilms_pkg::ST_IDLE: begin
        if (start) begin
          if (kind_i == ilms_pkg::KIND_RESTART) begin
            state_d = ilms_pkg::ST_CLEAR;
          end else if (!bad_in) begin
            state_d = ilms_pkg::ST_READ;
          end
        end
      end
      ilms_pkg::ST_READ:   if (rd_cnt_q == 3'd4) state_d = ilms_pkg::ST_LAST;
      ilms_pkg::ST_LAST:   state_d = ilms_pkg::ST_DECIDE;
      ilms_pkg::ST_DECIDE: state_d = (wrap && do_sum) ? ilms_pkg::ST_SQUARE
                                                       : ilms_pkg::ST_IDLE;
      ilms_pkg::ST_SQUARE: state_d = ilms_pkg::ST_ACCUM;
      ilms_pkg::ST_ACCUM:  state_d = ilms_pkg::ST_IDLE;
      default:             state_d = ilms_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    busy      = (state_q != ilms_pkg::ST_IDLE);
    ram_we    = 1'b0;
    ram_waddr = clr_cnt_q;
    ram_wdata = 1'b1;
    unique case (state_q)
      ilms_pkg::ST_CLEAR: ram_we = 1'b1;
      ilms_pkg::ST_DECIDE: begin
        ram_we    = flip;
        ram_waddr = {row_q, col_q};
        ram_wdata = ~taps_q[4];
      end
      default: ;
    endcase
  end

  // saturating sums
  logic signed [ilms_pkg::SUM_W:0]   sum_e_w, sum_m_w;
  logic [ilms_pkg::SQSUM_W:0]        sum_esq_w, sum_msq_w;
  logic [ilms_pkg::ABSSUM_W:0]       sum_abs_w;
  logic signed [ilms_pkg::SUM_W-1:0] acc_e_sat, acc_m_sat;
  localparam logic signed [ilms_pkg::SUM_W-1:0] SumMax = {1'b0, {(ilms_pkg::SUM_W-1){1'b1}}};
  localparam logic signed [ilms_pkg::SUM_W-1:0] SumMin = {1'b1, {(ilms_pkg::SUM_W-1){1'b0}}};

  always_comb begin
    sum_e_w   = $signed({acc_e_q[ilms_pkg::SUM_W-1], acc_e_q}) +
                (ilms_pkg::SUM_W+1)'(energy_q);
    sum_m_w   = $signed({acc_m_q[ilms_pkg::SUM_W-1], acc_m_q}) +
                (ilms_pkg::SUM_W+1)'(mag_q);
    sum_esq_w = {1'b0, acc_esq_q} + (ilms_pkg::SQSUM_W+1)'(esq_q);
    sum_msq_w = {1'b0, acc_msq_q} + (ilms_pkg::SQSUM_W+1)'(msq_q);
    sum_abs_w = {1'b0, acc_abs_q} + (ilms_pkg::ABSSUM_W+1)'(mabs_q);
    if (sum_e_w[ilms_pkg::SUM_W] != sum_e_w[ilms_pkg::SUM_W-1]) begin
      acc_e_sat = sum_e_w[ilms_pkg::SUM_W] ? SumMin : SumMax;
    end else begin
      acc_e_sat = sum_e_w[ilms_pkg::SUM_W-1:0];
    end
    if (sum_m_w[ilms_pkg::SUM_W] != sum_m_w[ilms_pkg::SUM_W-1]) begin
      acc_m_sat = sum_m_w[ilms_pkg::SUM_W] ? SumMin : SumMax;
    end else begin
      acc_m_sat = sum_m_w[ilms_pkg::SUM_W-1:0];
    end
  end

  // magnitudes for squaring
  logic [EW-1:0] eabs;
  logic [MW-1:0] mabs;
  assign eabs = energy_q[EW-1] ? EW'(-energy_q) : EW'(energy_q);
  assign mabs = mag_q[MW-1] ? MW'(-mag_q) : MW'(mag_q);

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ilms_pkg::ST_CLEAR;
      clr_cnt_q  <= '0;
      rd_cnt_q   <= '0;
      strobe_q   <= 1'b0;
      accepted_q <= 1'b0;
      bad_q      <= 1'b0;
      done_q     <= 1'b0;
      energy_q   <= EW'(0) - (EW'(ilms_pkg::SIDE_RST) * EW'(ilms_pkg::SIDE_RST) << 1);
      mag_q      <= MW'(ilms_pkg::SIDE_RST) * MW'(ilms_pkg::SIDE_RST);
      attempts_q <= '0;
      sweeps_q   <= '0;
      acc_e_q    <= '0;
      acc_m_q    <= '0;
      acc_esq_q  <= '0;
      acc_msq_q  <= '0;
      acc_abs_q  <= '0;
    end else begin
      state_q    <= state_d;
      strobe_q   <= 1'b0;
      accepted_q <= 1'b0;
      bad_q      <= 1'b0;
      done_q     <= 1'b0;
      unique case (state_q)
        ilms_pkg::ST_CLEAR: clr_cnt_q <= clr_cnt_q + AddrW'(1);
        ilms_pkg::ST_IDLE: begin
          rd_cnt_q <= '0;
          if (start) begin
            if (kind_i == ilms_pkg::KIND_RESTART) begin
              strobe_q   <= 1'b1;
              clr_cnt_q  <= '0;
              energy_q   <= EW'(0) - (EW'(side_sq) << 1);
              mag_q      <= MW'(side_sq);
              attempts_q <= '0;
              sweeps_q   <= '0;
              acc_e_q    <= '0;
              acc_m_q    <= '0;
              acc_esq_q  <= '0;
              acc_msq_q  <= '0;
              acc_abs_q  <= '0;
            end else if (bad_in) begin
              strobe_q <= 1'b1;
              bad_q    <= 1'b1;
            end
          end
        end
        ilms_pkg::ST_READ: rd_cnt_q <= rd_cnt_q + 3'd1;
        ilms_pkg::ST_DECIDE: begin
          if (flip) begin
            energy_q <= energy_new;
            mag_q    <= mag_new;
          end
          if (wrap) begin
            attempts_q <= '0;
            if (~&sweeps_q) sweeps_q <= sweeps_q + 1'b1;
          end else begin
            attempts_q <= attempts_inc;
          end
          // hold the result back when the sweep needs summing
          if (!(wrap && do_sum)) begin
            strobe_q   <= 1'b1;
            accepted_q <= flip;
            done_q     <= wrap;
          end else begin
            accepted_q <= flip;
          end
        end
        ilms_pkg::ST_SQUARE: accepted_q <= accepted_q;
        ilms_pkg::ST_ACCUM: begin
          acc_e_q   <= acc_e_sat;
          acc_m_q   <= acc_m_sat;
          acc_esq_q <= sum_esq_w[ilms_pkg::SQSUM_W] ? '1 : sum_esq_w[ilms_pkg::SQSUM_W-1:0];
          acc_msq_q <= sum_msq_w[ilms_pkg::SQSUM_W] ? '1 : sum_msq_w[ilms_pkg::SQSUM_W-1:0];
          acc_abs_q <= sum_abs_w[ilms_pkg::ABSSUM_W] ? '1 : sum_abs_w[ilms_pkg::ABSSUM_W-1:0];
          strobe_q   <= 1'b1;
          accepted_q <= accepted_q;
          done_q     <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (state_q == ilms_pkg::ST_IDLE && start) begin
      row_q    <= row_i;
      col_q    <= col_i;
      chance_q <= chance_i;
    end
    // shift in read data; the site ends up in the top tap
    if ((state_q == ilms_pkg::ST_READ && rd_cnt_q != 3'd0) ||
        state_q == ilms_pkg::ST_LAST) begin
      taps_q <= {taps_q[3:0], ram_rdata};
    end
    if (state_q == ilms_pkg::ST_SQUARE) begin
      esq_q  <= (2*EW)'(eabs) * (2*EW)'(eabs);
      msq_q  <= (2*MW)'(mabs) * (2*MW)'(mabs);
      mabs_q <= mabs;
    end
  end

  assign res_strobe_o    = strobe_q;
  assign accepted_o      = accepted_q;
  assign bad_site_o      = bad_q;
  assign sweep_done_o    = done_q;
  assign energy_o        = energy_q;
  assign magnetization_o = mag_q;
  assign sweep_count_o   = sweeps_q;
  assign sum_energy_o    = acc_e_q;
  assign sum_energy_sq_o = acc_esq_q;
  assign sum_mag_o       = acc_m_q;
  assign sum_mag_sq_o    = acc_msq_q;
  assign sum_abs_mag_o   = acc_abs_q;

`ifndef SYNTHESIS
  a_bad_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_strobe_o && bad_site_o) |-> (!accepted_o && !sweep_done_o))
    else $error("bad site reported with a flip or a sweep");

  a_done_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_strobe_o && sweep_done_o) |-> (attempts_q == '0))
    else $error("sweep reported without clearing the attempt count");

  a_ram_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == ilms_pkg::ST_CLEAR || state_q == ilms_pkg::ST_DECIDE))
    else $error("spin RAM written outside clear or write-back");

  a_flip_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && kind_i == ilms_pkg::KIND_FLIP && !bad_in)
      |=> (state_q == ilms_pkg::ST_READ && !res_strobe_o))
    else $error("valid flip attempt did not start its reads");
`endif

endmodule
